### rtl/tsfd_pkg.sv
`timescale 1ns / 1ps
package tsfd_pkg;

	localparam int CHANNELS = 2;
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TANH_TABLE_DEPTH = 256;
	localparam int TBL_AW = $clog2(TANH_TABLE_DEPTH);
	localparam int TBL_W = 32;

	localparam int SAMPLE_W = 24;
	localparam int COEF_W = 48;
	localparam int MAG_W = 47;
	localparam int PROD_W = 96;

	localparam logic signed [COEF_W-1:0] MAX48 = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] MIN48 = {1'b1, {(COEF_W-1){1'b0}}};

	localparam logic [COEF_W-1:0] K1_RST = 48'hFFFE_F555_565A;
	localparam logic [COEF_W-1:0] M1_RST = 48'd125;
	localparam logic [COEF_W-1:0] K2_RST = 48'hFFFB_44F5_6380;
	localparam logic [COEF_W-1:0] M2_RST = 48'd1929022;

	typedef enum logic [1:0] {
		REG_K1 = 2'd0,
		REG_M1 = 2'd1,
		REG_K2 = 2'd2,
		REG_M2 = 2'd3
	} reg_idx_t;

	// tanh table built at elaboration with the same integer recipe
	typedef logic [TBL_W-1:0] tbl_t [TANH_TABLE_DEPTH+1];

	// shift-subtract long division, only used while the table is built
	function automatic longint unsigned udiv64(input longint unsigned a,
			input longint unsigned b);
		longint unsigned q, r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic tbl_t build_tbl();
		tbl_t t;
		longint unsigned z, w, term, e, num, den;
		longint sum;
		for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
			z = (longint'(i) << 35) / TANH_TABLE_DEPTH;
			w = z >> 6;
			term = 64'd1 << 31;
			sum = longint'(64'd1 << 31);
			for (int n = 1; n <= 10; n++) begin
				term = udiv64((term * w) >> 31, 64'(n));
				if (n % 2 == 1) sum = sum - longint'(term);
				else sum = sum + longint'(term);
			end
			e = (sum < 0) ? 64'd0 : 64'(sum);
			if (e > (64'd1 << 31)) e = 64'd1 << 31;
			for (int n = 0; n < 6; n++) e = (e * e + (64'd1 << 30)) >> 31;
			num = (64'd1 << 31) - e;
			den = (64'd1 << 31) + e;
			t[i] = TBL_W'(udiv64((num << 30) + den / 2, den));
		end
		return t;
	endfunction

	localparam tbl_t TANH_TBL = build_tbl();

endpackage

### rtl/two_stage_fuzz_distortion_core.sv
`timescale 1ns / 1ps
// Channel  | Handshake                 | Payload
// in       | in_valid / in_ready       | sample_in[23:0], channel_in
// out      | out_valid / out_ready     | sample_out[23:0], channel_out
// cfg      | cfg_valid / cfg_ready     | cfg_index[1:0], cfg_data[47:0]
//
// One sample at a time: the next input beat is not taken until the result of the last
// one has been taken (the interpolation product is skipped past the table end).
// The time is set by a single bit-serial multiplier (four products, plus an
// interpolation product) and a shift-subtract divider by ten. arst_n resets control
// and integrator state and loads the coefficient registers with their reset values.
// in_ready drops while a sample is in work, its result is not yet taken, or a cfg
// write is pending (cfg wins over a new sample in the same cycle).
module two_stage_fuzz_distortion_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [23:0]   sample_in,
	input  logic                 channel_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [23:0]   sample_out,
	output logic                 channel_out,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [47:0]          cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_V1, ST_CLIP, ST_INTERP, ST_DIV, ST_V2, ST_OUT
	} state_t;

	localparam int W = tsfd_pkg::COEF_W;
	localparam int MW = tsfd_pkg::MAG_W;
	localparam int PW = tsfd_pkg::PROD_W;
	localparam int TW = tsfd_pkg::TBL_W;

	state_t state_q;
	logic signed [W-1:0] k1_q, m1_q, k2_q, m2_q;
	logic signed [W-1:0] s1_q [tsfd_pkg::CHANNELS];
	logic signed [W-1:0] s2_q [tsfd_pkg::CHANNELS];
	logic [tsfd_pkg::CH_W-1:0] ch_q;
	logic chan_q;

	// serial multiplier: magnitudes, accumulator, counter
	logic [W-1:0] mcand_q;        // multiplicand magnitude
	logic [W-1:0] mplier_q;       // shifting multiplier magnitude
	logic [PW-1:0] acc_q;
	logic [5:0] bit_q;
	logic neg_q;
	logic [1:0] prod_q;           // which product in a pair
	logic signed [W-1:0] pa_q;    // first product result
	logic stage2_q;               // working on stage two
	logic signed [W-1:0] v1_q;

	// clipper
	logic [TW+3:0] t_q;           // table value at the index
	logic [TW+3:0] rem_q;
	logic [TW+3:0] quo_q;
	logic [5:0] dcnt_q;

	function automatic logic [W-1:0] mag48(input logic signed [W-1:0] a);
		return a[W-1] ? (~a + 1'b1) : a;
	endfunction

	function automatic logic signed [W-1:0] sat_add(input logic signed [W:0] s);
		if (s[W] != s[W-1]) return s[W] ? tsfd_pkg::MIN48 : tsfd_pkg::MAX48;
		return s[W-1:0];
	endfunction

	// rounding and saturation of finished product
	logic [PW-1:0] rnd;
	logic signed [W-1:0] prod_res;
	always_comb begin
		rnd = acc_q + (PW'(1) << 31);
		if (rnd[PW-1:32+MW] != '0) prod_res = neg_q ? tsfd_pkg::MIN48 : tsfd_pkg::MAX48;
		else if (neg_q) prod_res = -$signed({1'b0, rnd[32+MW-1:32]});
		else prod_res = $signed({1'b0, rnd[32+MW-1:32]});
	end

	logic signed [W:0] vsum;
	logic signed [W-1:0] vres;
	logic signed [W+1:0] upd;
	logic signed [W-1:0] snew;
	logic signed [W-1:0] s_cur;
	always_comb begin
		vsum = {pa_q[W-1], pa_q} + {prod_res[W-1], prod_res};
		vres = sat_add(vsum);
		s_cur = stage2_q ? s2_q[ch_q] : s1_q[ch_q];
		upd = {vres[W-1], vres, 1'b0} - {{2{s_cur[W-1]}}, s_cur};
		if (upd[W+1:W-1] != 3'b000 && upd[W+1:W-1] != 3'b111)
			snew = upd[W+1] ? tsfd_pkg::MIN48 : tsfd_pkg::MAX48;
		else snew = upd[W-1:0];
	end

	// clipper index: p = |v1| * 5 * DEPTH (DEPTH a power of two)
	logic [W-1:0] v1mag;
	logic [W+2:0] p5;
	logic [W+2+tsfd_pkg::TBL_AW:0] p;
	logic [W+2+tsfd_pkg::TBL_AW-32:0] idx;
	logic [tsfd_pkg::TBL_AW:0] tix;
	logic [31:0] frac;
	logic [TW-1:0] ta, tb, td;
	always_comb begin
		v1mag = mag48(v1_q);
		p5 = {3'b0, v1mag} + {1'b0, v1mag, 2'b0};
		p = {p5, {tsfd_pkg::TBL_AW{1'b0}}};
		idx = p[$bits(p)-1:32];
		frac = p[31:0];
		tix = {1'b0, idx[tsfd_pkg::TBL_AW-1:0]};
		ta = tsfd_pkg::TANH_TBL[tix];
		tb = tsfd_pkg::TANH_TBL[tix + 1'b1];
		td = (tb > ta) ? tb - ta : '0;
	end

	// division by ten, restoring, one bit a cycle
	logic [TW+4:0] rtry;
	always_comb rtry = {rem_q, quo_q[TW+3]} - (TW+5)'(10);

	logic signed [W+3:0] y5;
	logic signed [W+3:0] qo;
	always_comb begin
		y5 = ({{4{vres[W-1]}}, vres} <<< 2) + {{4{vres[W-1]}}, vres} + (W+4)'(256);
		qo = y5 >>> 9;
	end

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign out_valid = (state_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k1_q <= tsfd_pkg::K1_RST;
			m1_q <= tsfd_pkg::M1_RST;
			k2_q <= tsfd_pkg::K2_RST;
			m2_q <= tsfd_pkg::M2_RST;
			for (int i = 0; i < tsfd_pkg::CHANNELS; i++) begin
				s1_q[i] <= '0;
				s2_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						case (tsfd_pkg::reg_idx_t'(cfg_index))
							tsfd_pkg::REG_K1: k1_q <= cfg_data;
							tsfd_pkg::REG_M1: m1_q <= cfg_data;
							tsfd_pkg::REG_K2: k2_q <= cfg_data;
							tsfd_pkg::REG_M2: m2_q <= cfg_data;
							default: ;
						endcase
					end
					if (in_valid && in_ready) begin
						// channel mod CHANNELS: one-bit channel with CHANNELS >= 2
						ch_q <= (tsfd_pkg::CHANNELS > 1) ? tsfd_pkg::CH_W'(channel_in) : '0;
						chan_q <= channel_in;
						mcand_q <= mag48(k1_q);
						mplier_q <= mag48(W'($signed(sample_in)) <<< 9);
						neg_q <= k1_q[W-1] ^ sample_in[23];
						acc_q <= '0;
						bit_q <= '0;
						prod_q <= '0;
						stage2_q <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mplier_q[0]) acc_q <= acc_q + (PW'(mcand_q) << bit_q);
					mplier_q <= mplier_q >> 1;
					bit_q <= bit_q + 1'b1;
					if (bit_q == 6'(W-1)) state_q <= ST_V1;
				end
				ST_V1: begin
					// after first product, start leak product; after second, finish
					if (prod_q == 2'd0) begin
						pa_q <= prod_res;
						prod_q <= 2'd1;
						mcand_q <= mag48(stage2_q ? m2_q : m1_q);
						mplier_q <= mag48(s_cur);
						neg_q <= (stage2_q ? m2_q[W-1] : m1_q[W-1]) ^ s_cur[W-1];
						acc_q <= '0;
						bit_q <= '0;
						state_q <= ST_MUL;
					end else if (!stage2_q) begin
						v1_q <= vres;
						s1_q[ch_q] <= snew;
						state_q <= ST_CLIP;
					end else begin
						s2_q[ch_q] <= snew;
						if (qo > (W+4)'(8388607)) sample_out <= 24'sh7FFFFF;
						else if (qo < -(W+4)'(8388608)) sample_out <= 24'sh800000;
						else sample_out <= qo[23:0];
						channel_out <= chan_q;
						state_q <= ST_OUT;
					end
				end
				ST_CLIP: begin
					// table lookup, then serial d*f into acc unless past the table end
					if (idx >= ($bits(idx))'(tsfd_pkg::TANH_TABLE_DEPTH)) begin
						t_q <= (TW+4)'(tsfd_pkg::TANH_TBL[tsfd_pkg::TANH_TABLE_DEPTH]);
						quo_q <= (TW+4)'(tsfd_pkg::TANH_TBL[tsfd_pkg::TANH_TABLE_DEPTH]) + 5;
						rem_q <= '0;
						dcnt_q <= '0;
						state_q <= ST_DIV;
					end else begin
						t_q <= (TW+4)'(ta);
						mcand_q <= W'(td);
						mplier_q <= W'(frac);
						acc_q <= '0;
						bit_q <= '0;
						state_q <= ST_INTERP;
					end
				end
				ST_INTERP: begin
					if (bit_q == 6'd32) begin
						quo_q <= t_q + (TW+4)'(rnd[PW-1:32]) + 5;
						rem_q <= '0;
						dcnt_q <= '0;
						state_q <= ST_DIV;
					end else begin
						if (mplier_q[0]) acc_q <= acc_q + (PW'(mcand_q) << bit_q);
						mplier_q <= mplier_q >> 1;
						bit_q <= bit_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (dcnt_q == 6'(TW+4)) begin
						// |c| = quo, sign of v1; start stage two gain product
						mcand_q <= mag48(k2_q);
						mplier_q <= W'(quo_q);
						neg_q <= k2_q[W-1] ^ (v1_q[W-1] && quo_q != '0);
						acc_q <= '0;
						bit_q <= '0;
						prod_q <= '0;
						stage2_q <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						if (!rtry[TW+4]) begin
							rem_q <= rtry[TW+3:0];
							quo_q <= {quo_q[TW+2:0], 1'b1};
						end else begin
							rem_q <= {rem_q[TW+2:0], quo_q[TW+3]};
							quo_q <= {quo_q[TW+2:0], 1'b0};
						end
						dcnt_q <= dcnt_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
		else $error("result dropped");
	a_mul_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (bit_q < 6'(W))) else $error("multiplier overrun");
`endif

endmodule

### dv/two_stage_fuzz_distortion_core_tb.sv
`timescale 1ns / 1ps
module two_stage_fuzz_distortion_core_tb;

	localparam int RST_CYCLES = 6;
	// 1600+ beats, stalls on both sides: allow well over 3x the run with no stalls
	localparam longint CYCLE_LIMIT = 4_000_000;
	localparam int PHASES = 8;
	localparam int BEATS_PER_PHASE = 200;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [23:0] sample_in;
	logic channel_in;
	logic out_valid;
	logic out_ready;
	logic signed [23:0] sample_out;
	logic channel_out;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [47:0] cfg_data;

	two_stage_fuzz_distortion_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.channel_in(channel_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.channel_out(channel_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// expected output beat
	typedef struct {
		logic signed [23:0] sample;
		logic channel;
	} fuzz_out_t;

	// directed row: expected value typed in only where obvious
	typedef struct {
		logic signed [23:0] sample;
		logic channel;
		bit known;
		logic signed [23:0] want;
	} drive_row_t;

	fuzz_out_t pending_out[$];
	int errors = 0;
	longint cycles = 0;
	bit no_idle = 0;

	// predictor copy of the coefficients and integrators
	logic signed [47:0] k1_q, m1_q, k2_q, m2_q;
	logic signed [47:0] integ1[2];
	logic signed [47:0] integ2[2];
	longint unsigned tanh_lut[tsfd_pkg::TANH_TABLE_DEPTH+1];

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("two_stage_fuzz_distortion_core_tb failed");
			$finish;
		end
	end

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	// tanh(y) in Q2.30 at y = 8i/depth, via exp series and repeated squaring
	function automatic void fill_tanh_lut();
		longint unsigned z, w, term, e, num, den;
		longint acc;
		for (int i = 0; i <= tsfd_pkg::TANH_TABLE_DEPTH; i++) begin
			z = (longint'(i) << 35) / tsfd_pkg::TANH_TABLE_DEPTH;
			w = z >> 6;
			term = 64'd1 << 31;
			acc = longint'(64'd1 << 31);
			for (int n = 1; n <= 10; n++) begin
				term = ((term * w) >> 31) / n;
				if (n % 2 == 1) acc = acc - longint'(term);
				else acc = acc + longint'(term);
			end
			e = (acc < 0) ? 64'd0 : 64'(acc);
			if (e > (64'd1 << 31)) e = 64'd1 << 31;
			for (int n = 0; n < 6; n++) e = (e * e + (64'd1 << 30)) >> 31;
			num = (64'd1 << 31) - e;
			den = (64'd1 << 31) + e;
			tanh_lut[i] = ((num << 30) + den / 2) / den;
		end
	endfunction

	function automatic logic signed [47:0] clamp48(logic signed [49:0] v);
		if (v > $signed({2'b00, tsfd_pkg::MAX48})) return tsfd_pkg::MAX48;
		if (v < $signed({2'b11, tsfd_pkg::MIN48})) return tsfd_pkg::MIN48;
		return v[47:0];
	endfunction

	// Q16.32 product, round half away from zero, saturate
	function automatic logic signed [47:0] q32_mul(logic signed [47:0] a, logic signed [47:0] b);
		logic [47:0] ma, mb;
		logic [95:0] pr;
		logic [46:0] mg;
		logic neg;
		neg = a[47] ^ b[47];
		ma = a[47] ? -a : a;
		mb = b[47] ? -b : b;
		pr = 96'(ma) * 96'(mb);
		pr = pr + 96'h8000_0000;
		if (pr[95:79] != 0) return neg ? tsfd_pkg::MIN48 : tsfd_pkg::MAX48;
		mg = pr[78:32];
		return neg ? -$signed({1'b0, mg}) : $signed({1'b0, mg});
	endfunction

	function automatic logic signed [47:0] add48(logic signed [47:0] a, logic signed [47:0] b);
		return clamp48({{2{a[47]}}, a} + {{2{b[47]}}, b});
	endfunction

	// trapezoidal update: s = 2v - s
	function automatic logic signed [47:0] integ_next(logic signed [47:0] v, logic signed [47:0] s);
		return clamp48(({{2{v[47]}}, v} <<< 1) - {{2{s[47]}}, s});
	endfunction

	function automatic logic signed [47:0] soft_clip(logic signed [47:0] v);
		logic [47:0] mag;
		longint unsigned p, idx, f, t, lo, hi, d, c;
		mag = v[47] ? -v : v;
		p = 64'(mag) * (5 * tsfd_pkg::TANH_TABLE_DEPTH);
		idx = p >> 32;
		f = p & 64'hFFFF_FFFF;
		if (idx >= tsfd_pkg::TANH_TABLE_DEPTH) begin
			t = tanh_lut[tsfd_pkg::TANH_TABLE_DEPTH]; // past the end of the table
		end else begin
			lo = tanh_lut[idx];
			hi = tanh_lut[idx+1];
			d = (hi > lo) ? hi - lo : 0; // a falling step counts as flat
			t = lo + ((d * f + 64'h8000_0000) >> 32);
		end
		c = (t + 5) / 10;
		return v[47] ? -$signed(48'(c)) : $signed(48'(c));
	endfunction

	function automatic logic signed [23:0] fuzz_predict(logic signed [23:0] smp, logic ch);
		logic signed [47:0] x, v1, c, v2;
		logic signed [51:0] y;
		logic signed [42:0] q;
		x = {{15{smp[23]}}, smp, 9'd0};
		v1 = add48(q32_mul(k1_q, x), q32_mul(m1_q, integ1[ch]));
		integ1[ch] = integ_next(v1, integ1[ch]);
		c = soft_clip(v1);
		v2 = add48(q32_mul(k2_q, c), q32_mul(m2_q, integ2[ch]));
		integ2[ch] = integ_next(v2, integ2[ch]);
		y = $signed({{4{v2[47]}}, v2}) * 52'sd5 + 52'sd256;
		q = y >>> 9;
		if (q > 43'sd8388607) return 24'sh7FFFFF;
		if (q < -43'sd8388608) return 24'sh800000;
		return q[23:0];
	endfunction

	// one input beat; valid is only lowered when a gap comes before it
	task automatic send_beat(logic signed [23:0] smp, logic ch, bit known,
			logic signed [23:0] want);
		int gap;
		fuzz_out_t eo;
		logic signed [23:0] pv;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= smp;
		channel_in <= ch;
		do @(posedge clk); while (!in_ready);
		pv = fuzz_predict(smp, ch);
		eo.sample = known ? want : pv;
		eo.channel = ch;
		pending_out.push_back(eo);
	endtask

	task automatic cfg_write(tsfd_pkg::reg_idx_t idx, logic signed [47:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			tsfd_pkg::REG_K1: k1_q = val;
			tsfd_pkg::REG_M1: m1_q = val;
			tsfd_pkg::REG_K2: k2_q = val;
			tsfd_pkg::REG_M2: m2_q = val;
			default: ;
		endcase
	endtask

	// hold the sender until every expected beat is back, then let the core settle
	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic signed [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	function automatic logic signed [23:0] rand_sample();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
			1: return $signed(24'($urandom_range(0, 511))) - 24'sd256;
			default: return 24'($urandom());
		endcase
	endfunction

	// output side: random stalls, compare against the oldest expectation
	initial begin
		int stall;
		fuzz_out_t eo;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_out.size() == 0) begin
				report_mismatch("unexpected beat sample_out", sample_out, 0);
			end else begin
				eo = pending_out.pop_front();
				if (sample_out !== eo.sample)
					report_mismatch("sample_out", sample_out, eo.sample);
				if (channel_out !== eo.channel)
					report_mismatch("channel_out", channel_out, eo.channel);
			end
		end
	end

	drive_row_t directed[] = '{
		// state is zero after reset, so silence gives silence on both channels
		'{24'sd0, 1'b0, 1'b1, 24'sd0},
		'{24'sd0, 1'b1, 1'b1, 24'sd0},
		'{24'sh7FFFFF, 1'b0, 1'b0, 24'sd0},
		'{24'sh800000, 1'b0, 1'b0, 24'sd0},
		'{24'sh7FFFFF, 1'b1, 1'b0, 24'sd0},
		'{24'sh7FFFFF, 1'b1, 1'b0, 24'sd0},
		'{24'sh800000, 1'b1, 1'b0, 24'sd0},
		'{24'sd1, 1'b0, 1'b0, 24'sd0},
		'{-24'sd1, 1'b0, 1'b0, 24'sd0},
		'{24'sh400000, 1'b1, 1'b0, 24'sd0},
		'{-24'sh400000, 1'b1, 1'b0, 24'sd0},
		'{24'sh555555, 1'b0, 1'b0, 24'sd0},
		'{24'shAAAAAA, 1'b1, 1'b0, 24'sd0},
		'{24'sd0, 1'b0, 1'b0, 24'sd0},
		'{24'sd0, 1'b1, 1'b0, 24'sd0}
	};

	initial begin
		logic signed [47:0] cv[4];
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_in = '0;
		channel_in = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = tsfd_pkg::REG_K1;
		cfg_data = '0;
		fill_tanh_lut();
		k1_q = tsfd_pkg::K1_RST;
		m1_q = tsfd_pkg::M1_RST;
		k2_q = tsfd_pkg::K2_RST;
		m2_q = tsfd_pkg::M2_RST;
		for (int k = 0; k < 2; k++) begin
			integ1[k] = '0;
			integ2[k] = '0;
		end
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[r])
			send_beat(directed[r].sample, directed[r].channel, directed[r].known,
				directed[r].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain_outputs();
				case (ph)
					1: cv = '{tsfd_pkg::MAX48, tsfd_pkg::MAX48, tsfd_pkg::MAX48,
						tsfd_pkg::MAX48};
					2: cv = '{tsfd_pkg::MIN48, tsfd_pkg::MIN48, tsfd_pkg::MIN48,
						tsfd_pkg::MIN48};
					3: cv = '{48'sd0, 48'sd0, 48'sd0, 48'sd0};
					5: begin
						// near the circuit's own values, so the clipper sees real swing
						cv[0] = tsfd_pkg::K1_RST + $signed(48'($urandom())) - 48'sh8000_0000;
						cv[1] = 48'($urandom_range(0, 32'h8000_0000));
						cv[2] = tsfd_pkg::K2_RST + $signed(48'($urandom())) - 48'sh8000_0000;
						cv[3] = 48'($urandom_range(0, 32'h8000_0000));
					end
					7: cv = '{tsfd_pkg::K1_RST, tsfd_pkg::M1_RST, tsfd_pkg::K2_RST,
						tsfd_pkg::M2_RST};
					default: cv = '{rand48(), rand48(), rand48(), rand48()};
				endcase
				cfg_write(tsfd_pkg::REG_K1, cv[0]);
				cfg_write(tsfd_pkg::REG_M1, cv[1]);
				cfg_write(tsfd_pkg::REG_K2, cv[2]);
				cfg_write(tsfd_pkg::REG_M2, cv[3]);
			end
			no_idle = (ph % 3 == 2);
			for (int n = 0; n < BEATS_PER_PHASE; n++)
				send_beat(rand_sample(), 1'($urandom_range(0, 1)), 1'b0, 24'sd0);
		end

		in_valid <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (errors == 0) begin
			$display("two_stage_fuzz_distortion_core_tb passed");
		end else begin
			$display("two_stage_fuzz_distortion_core_tb failed");
		end
		$finish;
	end

endmodule
